// ----- rtl/core/brme_pkg.sv -----
package brme_pkg;

  localparam int MAX_BOXES      = 32;
  localparam int MAX_REGION_IDS = 64;
  localparam int COORD_BITS     = 32;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 5;
  localparam int REGION_W = 6;
  localparam int MASK_W   = 64;
  localparam int IN_W     = 32;
  localparam int AXES     = 3;

  localparam int CELL_IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int SLOT_CMP_W = (CELL_IDX_W > SLOT_W) ? CELL_IDX_W : SLOT_W;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CAMERA = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [REGION_W:0] REGION_LIMIT = (REGION_W+1)'(MAX_REGION_IDS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MASK_W-1:0]            mask_t;

  typedef struct packed {
    logic                 valid;
    logic [OP_W-1:0]      op;
    logic [SLOT_W-1:0]    slot;
    logic                 is_camera;
    logic                 is_cube;
    logic [REGION_W-1:0]  region;
    coord_t [AXES-1:0]    lo;
    coord_t [AXES-1:0]    hi;
    mask_t                mask;
  } word_t;

  function automatic coord_t to_coord(input logic signed [IN_W-1:0] v);
    return coord_t'(v);
  endfunction

  function automatic mask_t id_bit(input logic [REGION_W-1:0] id);
    mask_t b;
    b = '0;
    if ({1'b0, id} < REGION_LIMIT) begin
      b = mask_t'(1) << id;
    end
    return b;
  endfunction

endpackage

// ----- rtl/core/box_region_mask_engine_core.sv -----
// channel  | ports                                    | handshake
// ---------+------------------------------------------+------------------------------
// input    | in_operation .. in_hi_z                  | taken when start && !busy
// result   | out_region_mask, out_in_active_region    | out_valid, one cycle, no stall
//
// Each word walks a row of MAX_BOXES cells, one cell per cycle; a new word may enter
// every cycle while busy is low. Its result strobe is registered from the last cell.
// busy is high during reset and the first cycle after it; reset empties every slot
// and the camera mask. The result side cannot stall, so only busy holds off input.
module box_region_mask_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [brme_pkg::OP_W-1:0]           in_operation,
  input  logic [brme_pkg::SLOT_W-1:0]         in_slot,
  input  logic                                in_is_camera,
  input  logic                                in_is_cube,
  input  logic [brme_pkg::REGION_W-1:0]       in_region_id,
  input  logic signed [brme_pkg::IN_W-1:0]    in_lo_x,
  input  logic signed [brme_pkg::IN_W-1:0]    in_hi_x,
  input  logic signed [brme_pkg::IN_W-1:0]    in_lo_y,
  input  logic signed [brme_pkg::IN_W-1:0]    in_hi_y,
  input  logic signed [brme_pkg::IN_W-1:0]    in_lo_z,
  input  logic signed [brme_pkg::IN_W-1:0]    in_hi_z,
  output logic                                out_valid,
  output logic [brme_pkg::MASK_W-1:0]         out_region_mask,
  output logic                                out_in_active_region
);

  brme_pkg::word_t link [brme_pkg::MAX_BOXES+1];
  brme_pkg::word_t head;
  brme_pkg::word_t tail;

  logic                   busy_r;
  brme_pkg::mask_t        camera_mask_r;
  brme_pkg::mask_t        camera_mask_nxt;
  logic                   out_valid_r;
  brme_pkg::mask_t        out_mask_r;
  brme_pkg::mask_t        out_mask_nxt;
  logic                   out_active_r;
  logic                   out_active_nxt;
  logic                   camera_op;

  assign camera_op = (in_operation == brme_pkg::OP_CAMERA);

  always_comb begin
    head           = '0;
    head.valid     = start && !busy_r;
    head.op        = in_operation;
    head.slot      = in_slot;
    head.is_camera = in_is_camera;
    head.is_cube   = in_is_cube;
    head.region    = in_region_id;
    head.lo[0]     = brme_pkg::to_coord(in_lo_x);
    head.lo[1]     = brme_pkg::to_coord(in_lo_y);
    head.lo[2]     = brme_pkg::to_coord(in_lo_z);
    head.hi[0]     = brme_pkg::to_coord(camera_op ? in_lo_x : in_hi_x);
    head.hi[1]     = brme_pkg::to_coord(camera_op ? in_lo_y : in_hi_y);
    head.hi[2]     = brme_pkg::to_coord(camera_op ? in_lo_z : in_hi_z);
    head.mask      = '0;
  end

  assign link[0] = head;

  for (genvar i = 0; i < brme_pkg::MAX_BOXES; i++) begin : g_cell
    brme_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (brme_pkg::SLOT_CMP_W'(i)),
      .word_i   (link[i]),
      .word_o   (link[i+1])
    );
  end

  assign tail = link[brme_pkg::MAX_BOXES];

  always_comb begin
    camera_mask_nxt = camera_mask_r;
    out_mask_nxt    = '0;
    out_active_nxt  = 1'b0;
    case (tail.op)
      brme_pkg::OP_CAMERA: begin
        camera_mask_nxt = tail.mask;
        out_mask_nxt    = tail.mask;
      end
      brme_pkg::OP_QUERY: begin
        out_mask_nxt   = tail.mask;
        out_active_nxt = |(tail.mask & camera_mask_r);
      end
      default: begin
        out_mask_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b1;
      camera_mask_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= tail.valid;
      if (tail.valid) begin
        camera_mask_r <= camera_mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      out_mask_r   <= out_mask_nxt;
      out_active_r <= out_active_nxt;
    end
  end

  assign busy                 = busy_r;
  assign out_valid            = out_valid_r;
  assign out_region_mask      = out_mask_r;
  assign out_in_active_region = out_active_r;

  a_active_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_active_region |-> out_region_mask != '0)
    else $error("active flag without mask bits");

  a_strobe_follows_tail: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> out_valid == $past(tail.valid))
    else $error("result strobe out of step with row");

  a_camera_latch: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid && (tail.op == brme_pkg::OP_CAMERA) |=> camera_mask_r == $past(tail.mask))
    else $error("camera mask not latched");

endmodule

// ----- rtl/core/brme_cell.sv -----
module brme_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [brme_pkg::SLOT_CMP_W-1:0] cell_idx,
  input  brme_pkg::word_t                 word_i,
  output brme_pkg::word_t                 word_o
);

  logic                            flag_cam_r;
  logic                            flag_cube_r;
  logic [brme_pkg::REGION_W-1:0]   region_r;
  brme_pkg::coord_t                lo_r [brme_pkg::AXES];
  brme_pkg::coord_t                hi_r [brme_pkg::AXES];
  brme_pkg::word_t                 word_r;
  brme_pkg::word_t                 word_nxt;

  logic hit;
  logic write_en;
  logic enclosed;
  logic sel;

  assign hit      = (brme_pkg::SLOT_CMP_W'(word_i.slot) == cell_idx);
  assign write_en = word_i.valid && (word_i.op == brme_pkg::OP_LOAD) && hit;

  always_comb begin
    enclosed = 1'b1;
    for (int a = 0; a < brme_pkg::AXES; a++) begin
      if (($signed(word_i.lo[a]) < $signed(lo_r[a])) ||
          ($signed(word_i.hi[a]) > $signed(hi_r[a]))) begin
        enclosed = 1'b0;
      end
    end
  end

  always_comb begin
    case (word_i.op)
      brme_pkg::OP_CAMERA: sel = flag_cam_r;
      brme_pkg::OP_QUERY:  sel = flag_cube_r;
      default:             sel = 1'b0;
    endcase
  end

  always_comb begin
    word_nxt = word_i;
    if (word_i.valid && sel && enclosed) begin
      word_nxt.mask = word_i.mask | brme_pkg::id_bit(region_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_cam_r  <= 1'b0;
      flag_cube_r <= 1'b0;
      word_r      <= '0;
    end else begin
      word_r <= word_nxt;
      if (write_en) begin
        flag_cam_r  <= word_i.is_camera;
        flag_cube_r <= word_i.is_cube;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_en && (word_i.is_camera || word_i.is_cube)) begin
      region_r <= word_i.region;
      for (int a = 0; a < brme_pkg::AXES; a++) begin
        lo_r[a] <= word_i.lo[a];
        hi_r[a] <= word_i.hi[a];
      end
    end
  end

  assign word_o = word_r;

  a_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
    write_en |=> (flag_cam_r == $past(word_i.is_camera)) &&
                 (flag_cube_r == $past(word_i.is_cube)))
    else $error("cell flags not written by load");

  a_load_keeps_mask: assert property (@(posedge clk) disable iff (!rst_n)
    word_i.valid && ((word_i.op == brme_pkg::OP_LOAD) || (word_i.op == brme_pkg::OP_NONE))
    |=> word_o.mask == $past(word_i.mask))
    else $error("mask changed by non-search word");

  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    word_i.valid |=> (word_o.mask & $past(word_i.mask)) == $past(word_i.mask))
    else $error("cell dropped mask bits");

  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> word_o.valid == $past(word_i.valid))
    else $error("word lost or invented in cell");

endmodule
